// File: design/jalu_pkg.sv
// Package with the opcodes, status codes and pipeline constants of the integer ALU.
package jalu_pkg;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned OP_W = 5;
    localparam int unsigned ST_W = 2;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned PREP_STAGE = 1;
    localparam int unsigned LAST_STAGE = DIV_STEPS + 2;

    localparam logic [OP_W-1:0] OP_ADD = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV = 5'd3;
    localparam logic [OP_W-1:0] OP_MOD = 5'd4;
    localparam logic [OP_W-1:0] OP_AND = 5'd5;
    localparam logic [OP_W-1:0] OP_OR = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR = 5'd7;
    localparam logic [OP_W-1:0] OP_SHL = 5'd8;
    localparam logic [OP_W-1:0] OP_SAR = 5'd9;
    localparam logic [OP_W-1:0] OP_SHR = 5'd10;
    localparam logic [OP_W-1:0] OP_EQ = 5'd11;
    localparam logic [OP_W-1:0] OP_NE = 5'd12;
    localparam logic [OP_W-1:0] OP_LT = 5'd13;
    localparam logic [OP_W-1:0] OP_LE = 5'd14;
    localparam logic [OP_W-1:0] OP_GT = 5'd15;
    localparam logic [OP_W-1:0] OP_GE = 5'd16;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [4:0] INT_SHIFT_MASK = 5'h1f;
    localparam logic [5:0] LONG_SHIFT_MASK = 6'h3f;
    localparam logic [DATA_W-1:0] LONG_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] INT_MIN = 64'hffff_ffff_8000_0000;
    localparam logic [DATA_W-1:0] MINUS_ONE = '1;

    function automatic logic [DATA_W-1:0] sext32(input logic [DATA_W-1:0] v);
        return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction
endpackage

// File: design/jalu_if.sv
// Handshake interfaces for the request and response channels of the integer ALU.
interface jalu_req_if import jalu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic              is_long;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;

    modport source (output valid, op, is_long, operand_a, operand_b, input ready);
    modport sink (input valid, op, is_long, operand_a, operand_b, output ready);
endinterface

interface jalu_rsp_if import jalu_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic [ST_W-1:0]   status;

    modport source (output valid, result, status, input ready);
    modport sink (input valid, result, status, output ready);
endinterface

// File: design/java_integer_alu.sv
// Top level of the pipelined Java int/long integer ALU.
// The ALU accepts one transaction per cycle while the output is not stalled, and presents each
// result in order; the divider resolves one quotient bit in each of 64 pipeline stages, with
// one preparation stage before it, one input stage and one output stage. All operations travel
// through the same pipeline, so the latency is the same for every opcode. A stalled output
// holds the whole pipeline without loss.
module java_integer_alu import jalu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jalu_req_if.sink     i_req,
    jalu_rsp_if.source   o_rsp
);
    logic                  w_en;
    logic                  r_v    [0:LAST_STAGE];
    logic [OP_W-1:0]       r_op   [0:LAST_STAGE];
    logic                  r_wide [0:LAST_STAGE];
    logic [DATA_W-1:0]     r_res  [0:LAST_STAGE];
    logic [ST_W-1:0]       r_st   [0:LAST_STAGE];
    logic                  r_negq [0:LAST_STAGE];
    logic                  r_negr [0:LAST_STAGE];
    logic [DATA_W-1:0]     r_b0;
    logic [DATA_W-1:0]     r_rem  [PREP_STAGE:LAST_STAGE-1];
    logic [DATA_W-1:0]     r_quo  [PREP_STAGE:LAST_STAGE-1];
    logic [DATA_W-1:0]     r_dvs  [PREP_STAGE:LAST_STAGE-1];
    logic [DATA_W-1:0]     r_pp0;
    logic [HALF_W-1:0]     r_pp1;
    logic [HALF_W-1:0]     r_pp2;

    logic [DATA_W-1:0]     n_rem  [PREP_STAGE+1:LAST_STAGE-1];
    logic [DATA_W-1:0]     n_quo  [PREP_STAGE+1:LAST_STAGE-1];

    logic [DATA_W-1:0]     w_a;
    logic [DATA_W-1:0]     w_b;
    logic [5:0]            w_d;
    logic [DATA_W-1:0]     n_res1;
    logic [ST_W-1:0]       n_st1;
    logic [DATA_W-1:0]     n_res2;
    logic [DATA_W-1:0]     n_fin;

    assign w_en = !r_v[LAST_STAGE] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = r_v[LAST_STAGE];
    assign o_rsp.result = r_res[LAST_STAGE];
    assign o_rsp.status = r_st[LAST_STAGE];

    always_comb begin
        w_a = r_wide[0] ? r_res[0] : sext32(r_res[0]);
        w_b = r_wide[0] ? r_b0 : sext32(r_b0);
        w_d = r_wide[0] ? (w_b[5:0] & LONG_SHIFT_MASK) : {1'b0, w_b[4:0] & INT_SHIFT_MASK};
        n_st1 = ST_OK;
        if (r_op[0] == OP_DIV || r_op[0] == OP_MOD) begin
            if (w_b == '0) begin
                n_st1 = ST_DIV_ZERO;
            end else if (w_a == (r_wide[0] ? LONG_MIN : INT_MIN) && w_b == MINUS_ONE) begin
                n_st1 = ST_OVERFLOW;
            end
        end
        case (r_op[0])
            OP_ADD: n_res1 = w_a + w_b;
            OP_SUB: n_res1 = w_a - w_b;
            OP_AND: n_res1 = w_a & w_b;
            OP_OR:  n_res1 = w_a | w_b;
            OP_XOR: n_res1 = w_a ^ w_b;
            OP_SHL: n_res1 = w_a << w_d;
            OP_SAR: n_res1 = DATA_W'($signed(w_a) >>> w_d);
            OP_SHR: n_res1 = r_wide[0] ? (w_a >> w_d)
                                       : ({{HALF_W{1'b0}}, w_a[HALF_W-1:0]} >> w_d);
            OP_EQ:  n_res1 = DATA_W'(w_a == w_b);
            OP_NE:  n_res1 = DATA_W'(w_a != w_b);
            OP_LT:  n_res1 = DATA_W'($signed(w_a) < $signed(w_b));
            OP_LE:  n_res1 = DATA_W'($signed(w_a) <= $signed(w_b));
            OP_GT:  n_res1 = DATA_W'($signed(w_a) > $signed(w_b));
            OP_GE:  n_res1 = DATA_W'($signed(w_a) >= $signed(w_b));
            default: n_res1 = '0;
        endcase
    end

    always_comb begin
        n_res2 = r_res[PREP_STAGE];
        if (r_op[PREP_STAGE] == OP_MUL) begin
            n_res2 = r_pp0 + {r_pp1 + r_pp2, {HALF_W{1'b0}}};
        end
    end

    for (genvar k = PREP_STAGE + 1; k < LAST_STAGE; k++) begin : g_div
        logic [DATA_W:0]   w_shift;
        logic [DATA_W+1:0] w_diff;
        always_comb begin
            w_shift = {r_rem[k-1], r_quo[k-1][DATA_W-1]};
            w_diff = {1'b0, w_shift} - {2'b00, r_dvs[k-1]};
            if (!w_diff[DATA_W+1]) begin
                n_rem[k] = w_diff[DATA_W-1:0];
                n_quo[k] = {r_quo[k-1][DATA_W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_shift[DATA_W-1:0];
                n_quo[k] = {r_quo[k-1][DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_fin = r_res[LAST_STAGE-1];
        if (r_op[LAST_STAGE-1] == OP_DIV) begin
            n_fin = r_negq[LAST_STAGE-1] ? -r_quo[LAST_STAGE-1] : r_quo[LAST_STAGE-1];
        end else if (r_op[LAST_STAGE-1] == OP_MOD) begin
            n_fin = r_negr[LAST_STAGE-1] ? -r_rem[LAST_STAGE-1] : r_rem[LAST_STAGE-1];
        end
        if (r_st[LAST_STAGE-1] != ST_OK) begin
            n_fin = '0;
        end
        if (!r_wide[LAST_STAGE-1] && r_op[LAST_STAGE-1] <= OP_SHR) begin
            n_fin = sext32(n_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST_STAGE; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= i_req.valid;
            for (int k = 1; k <= LAST_STAGE; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op[0] <= i_req.op;
            r_wide[0] <= i_req.is_long;
            r_res[0] <= i_req.operand_a;
            r_st[0] <= ST_OK;
            r_negq[0] <= 1'b0;
            r_negr[0] <= 1'b0;
            r_b0 <= i_req.operand_b;
            for (int k = 1; k <= LAST_STAGE; k++) begin
                r_op[k] <= r_op[k-1];
                r_wide[k] <= r_wide[k-1];
            end
            for (int k = PREP_STAGE + 1; k <= LAST_STAGE; k++) begin
                r_st[k] <= r_st[k-1];
                r_negq[k] <= r_negq[k-1];
                r_negr[k] <= r_negr[k-1];
            end
            for (int k = PREP_STAGE + 2; k < LAST_STAGE; k++) begin
                r_res[k] <= r_res[k-1];
            end
            r_res[PREP_STAGE] <= n_res1;
            r_st[PREP_STAGE] <= n_st1;
            r_negq[PREP_STAGE] <= w_a[DATA_W-1] ^ w_b[DATA_W-1];
            r_negr[PREP_STAGE] <= w_a[DATA_W-1];
            r_pp0 <= w_a[HALF_W-1:0] * w_b[HALF_W-1:0];
            r_pp1 <= HALF_W'(w_a[HALF_W-1:0] * w_b[DATA_W-1:HALF_W]);
            r_pp2 <= HALF_W'(w_a[DATA_W-1:HALF_W] * w_b[HALF_W-1:0]);
            r_rem[PREP_STAGE] <= '0;
            r_quo[PREP_STAGE] <= w_a[DATA_W-1] ? -w_a : w_a;
            r_dvs[PREP_STAGE] <= w_b[DATA_W-1] ? -w_b : w_b;
            r_res[PREP_STAGE+1] <= n_res2;
            for (int k = PREP_STAGE + 1; k < LAST_STAGE; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvs[k] <= r_dvs[k-1];
            end
            r_res[LAST_STAGE] <= n_fin;
        end
    end
endmodule

// File: design/jalu_chk.sv
// Port-level checker for the integer ALU, with the bind that attaches it to the top level.
module jalu_chk import jalu_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_result,
    input logic [ST_W-1:0]   i_status
);
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_DIV_ZERO || i_status == ST_OVERFLOW))
        else $error("Invalid status code on a response transaction.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> i_result == '0)
        else $error("A failed division returned a non-zero result.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_result) && $stable(i_status)))
        else $error("A stalled response transaction changed.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stall.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Response valid after reset.");
endmodule

bind java_integer_alu jalu_chk u_jalu_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_result    (o_rsp.result),
    .i_status    (o_rsp.status)
);

// File: tb/sv/tb.sv
// Self-checking testbench for the pipelined Java int/long integer ALU.
module tb;
    import jalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              is_long;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [ST_W-1:0]   status;
    } alu_res_t;

    typedef struct {
        alu_op_t  req;
        logic     known;
        alu_res_t res;
    } stim_row_t;

    localparam int unsigned LATENCY = 67;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    jalu_req_if req_if ();
    jalu_rsp_if rsp_if ();

    java_integer_alu dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_rsp(rsp_if.source)
    );

    always #1 i_clk = ~i_clk;

    alu_res_t   pending_results[$];
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    function automatic alu_res_t alu_predict(alu_op_t t);
        logic [DATA_W-1:0] a, b, r, minv;
        logic [5:0]        shamt;
        alu_res_t          res;
        a = t.a;
        b = t.b;
        r = '0;
        res.status = ST_OK;
        if (!t.is_long) begin
            a = {{32{a[31]}}, a[31:0]};
            b = {{32{b[31]}}, b[31:0]};
        end
        shamt = t.is_long ? b[5:0] : {1'b0, b[4:0]};
        minv = t.is_long ? LONG_MIN : INT_MIN;
        case (t.op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    res.status = ST_DIV_ZERO;
                end else if (a == minv && b == MINUS_ONE) begin
                    res.status = ST_OVERFLOW;
                end else if (t.op == OP_DIV) begin
                    r = $signed(a) / $signed(b);
                end else begin
                    r = $signed(a) % $signed(b);
                end
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL: r = a << shamt;
            OP_SAR: r = $signed(a) >>> shamt;
            OP_SHR: r = t.is_long ? (a >> shamt) : ({32'd0, a[31:0]} >> shamt);
            OP_EQ:  r = 64'(a == b);
            OP_NE:  r = 64'(a != b);
            OP_LT:  r = 64'($signed(a) < $signed(b));
            OP_LE:  r = 64'($signed(a) <= $signed(b));
            OP_GT:  r = 64'($signed(a) > $signed(b));
            OP_GE:  r = 64'($signed(a) >= $signed(b));
            default: r = '0;
        endcase
        if (!t.is_long && t.op <= OP_SHR) begin
            r = {{32{r[31]}}, r[31:0]};
        end
        res.result = r;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = LONG_MIN;
            1: v = MINUS_ONE;
            2: v = '0;
            3: v = INT_MIN;
            4: v = 64'($signed($urandom_range(0, 20)) - 10);
            5: v = {$urandom, 32'h8000_0000};
            6: v = 64'h7fff_ffff_ffff_ffff;
            default: ;
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        alu_res_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h status %0d", $time,
                         rsp_if.result, rsp_if.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.result !== want.result) begin
                    $display("%0t: result expected %h actual %h", $time,
                             want.result, rsp_if.result);
                    error_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_op(alu_op_t t, logic known, alu_res_t fixed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= t.op;
        req_if.is_long   <= t.is_long;
        req_if.operand_a <= t.a;
        req_if.operand_b <= t.b;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(known ? fixed : alu_predict(t));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    stim_row_t directed[] = '{
        '{'{OP_ADD, 1'b1, 64'h7fff_ffff_ffff_ffff, 64'd1}, 1'b1, '{LONG_MIN, ST_OK}},
        '{'{OP_ADD, 1'b0, 64'h0000_0000_7fff_ffff, 64'd1}, 1'b1, '{INT_MIN, ST_OK}},
        '{'{OP_SUB, 1'b1, LONG_MIN, 64'd1}, 1'b1, '{64'h7fff_ffff_ffff_ffff, ST_OK}},
        '{'{OP_MUL, 1'b0, 64'hdead_beef_0001_0000, 64'h0001_0000}, 1'b0, '{'0, ST_OK}},
        '{'{OP_DIV, 1'b1, 64'd7, 64'd0}, 1'b1, '{'0, ST_DIV_ZERO}},
        '{'{OP_MOD, 1'b0, 64'd7, 64'h1234_5678_0000_0000}, 1'b1, '{'0, ST_DIV_ZERO}},
        '{'{OP_DIV, 1'b1, LONG_MIN, MINUS_ONE}, 1'b1, '{'0, ST_OVERFLOW}},
        '{'{OP_MOD, 1'b0, 64'h0000_0000_8000_0000, 64'h0000_0000_ffff_ffff},
          1'b1, '{'0, ST_OVERFLOW}},
        '{'{OP_DIV, 1'b0, LONG_MIN, MINUS_ONE}, 1'b1, '{'0, ST_OK}},
        '{'{OP_DIV, 1'b1, 64'hffff_ffff_ffff_fff9, 64'd2}, 1'b0, '{'0, ST_OK}},
        '{'{OP_MOD, 1'b1, 64'hffff_ffff_ffff_fff9, 64'd2}, 1'b0, '{'0, ST_OK}},
        '{'{OP_AND, 1'b1, MINUS_ONE, 64'h0f0f_0f0f_0f0f_0f0f}, 1'b0, '{'0, ST_OK}},
        '{'{OP_OR, 1'b0, 64'h1, 64'h8000_0000}, 1'b0, '{'0, ST_OK}},
        '{'{OP_XOR, 1'b1, MINUS_ONE, MINUS_ONE}, 1'b1, '{'0, ST_OK}},
        '{'{OP_SHL, 1'b0, 64'd1, 64'd33}, 1'b1, '{64'd2, ST_OK}},
        '{'{OP_SHL, 1'b1, 64'd1, 64'd127}, 1'b1, '{LONG_MIN, ST_OK}},
        '{'{OP_SAR, 1'b1, LONG_MIN, 64'd63}, 1'b1, '{MINUS_ONE, ST_OK}},
        '{'{OP_SAR, 1'b0, 64'h8000_0000, 64'hffff_ffff_ffff_ffff}, 1'b1, '{MINUS_ONE, ST_OK}},
        '{'{OP_SHR, 1'b0, MINUS_ONE, 64'd31}, 1'b1, '{64'd1, ST_OK}},
        '{'{OP_SHR, 1'b1, MINUS_ONE, 64'd64}, 1'b1, '{MINUS_ONE, ST_OK}},
        '{'{OP_EQ, 1'b0, 64'h1_0000_0005, 64'h5}, 1'b1, '{64'd1, ST_OK}},
        '{'{OP_NE, 1'b1, 64'h1_0000_0005, 64'h5}, 1'b1, '{64'd1, ST_OK}},
        '{'{OP_LT, 1'b1, LONG_MIN, 64'd0}, 1'b1, '{64'd1, ST_OK}},
        '{'{OP_LE, 1'b0, 64'h8000_0000, 64'h8000_0000}, 1'b1, '{64'd1, ST_OK}},
        '{'{OP_GT, 1'b0, 64'h8000_0000, 64'd1}, 1'b1, '{64'd0, ST_OK}},
        '{'{OP_GE, 1'b1, 64'd0, MINUS_ONE}, 1'b1, '{64'd1, ST_OK}},
        '{'{5'd31, 1'b1, MINUS_ONE, MINUS_ONE}, 1'b1, '{64'd0, ST_OK}}
    };

    initial begin
        alu_op_t  t;
        alu_res_t none;
        none = '0;
        req_if.valid     <= 1'b0;
        req_if.op        <= '0;
        req_if.is_long   <= 1'b0;
        req_if.operand_a <= '0;
        req_if.operand_b <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            send_op(directed[i].req, directed[i].known, directed[i].res);
        end
        // The sender holds off here until the pipeline has drained completely.
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
            for (int n = 0; n < 450; n++) begin
                t.op      = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                                         : 5'($urandom_range(0, 16));
                t.is_long = 1'($urandom);
                t.a       = random_operand();
                t.b       = random_operand();
                send_op(t, 1'b0, none);
            end
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[java_integer_alu] OK");
        end else begin
            $display("[java_integer_alu] ERROR");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("[java_integer_alu] ERROR");
        $finish;
    end
endmodule
